// ----- rtl/tsa_pkg.sv -----
// Shared constants and types for the triangle strip assembly block.
`default_nettype none
package tsa_pkg;

	// Field widths.
	localparam int WORD_W = 16;
	localparam int CODE_W = 14;
	localparam int IDX_W  = 11;

	// Bit 15 of a strip word restarts the strip.
	localparam int RESTART_BIT = 15;

	// Codes at or above this base are scaled down by the stride.
	localparam logic [CODE_W-1:0] IDX_BASE = 14'h0408;

	// Division by 36 is a shift by two followed by a division by 9, done as a
	// multiplication by ceil(2^15 / 9); exact for every quotient input below 2^15.
	localparam int                QUOT_IN_W   = CODE_W - 2;
	localparam logic [QUOT_IN_W-1:0] RECIP_NINE = 12'd3641;
	localparam int                RECIP_SHIFT = 15;
	localparam int                PROD_W      = 2 * QUOT_IN_W;
	localparam int                QUOT_W      = PROD_W - RECIP_SHIFT;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_OFFSET = 1'b0,
		REG_WINDOW_COUNT  = 1'b1
	} cfg_reg_t;

	// Number of strip vertices currently held.
	typedef enum logic [1:0] {
		HELD_NONE = 2'd0,
		HELD_ONE  = 2'd1,
		HELD_TWO  = 2'd2
	} held_t;

endpackage
`default_nettype wire

// ----- rtl/tsa_if.sv -----
// Valid/ready channel interfaces for strip words in and triangles out.
`default_nettype none
interface tsa_in_if;
	logic                         valid;
	logic                         ready;
	logic [tsa_pkg::WORD_W-1:0]   strip_word;
	logic                         strip_start;

	modport source (output valid, output strip_word, output strip_start, input ready);
	modport sink   (input valid, input strip_word, input strip_start, output ready);
endinterface

interface tsa_out_if;
	logic                        valid;
	logic                        ready;
	logic [tsa_pkg::IDX_W-1:0]   tri_index_a;
	logic [tsa_pkg::IDX_W-1:0]   tri_index_b;
	logic [tsa_pkg::IDX_W-1:0]   tri_index_c;
	logic [tsa_pkg::IDX_W-1:0]   local_a;
	logic [tsa_pkg::IDX_W-1:0]   local_b;
	logic [tsa_pkg::IDX_W-1:0]   local_c;
	logic                        status;

	modport source (output valid, output tri_index_a, output tri_index_b, output tri_index_c,
		output local_a, output local_b, output local_c, output status, input ready);
	modport sink   (input valid, input tri_index_a, input tri_index_b, input tri_index_c,
		input local_a, input local_b, input local_c, input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/tsa_decode.sv -----
// Decoder from an encoded strip word to a buffer vertex index.
`default_nettype none
module tsa_decode (
	input  wire logic [tsa_pkg::WORD_W-1:0] word,
	output logic      [tsa_pkg::IDX_W-1:0]  vertex
);
	import tsa_pkg::*;

	logic [CODE_W-1:0]    code;
	logic [CODE_W-1:0]    diff;
	logic [QUOT_IN_W-1:0] quarter;
	logic [PROD_W-1:0]    prod;
	logic [QUOT_W-1:0]    quot;

	// Scaled codes: (code - base) / 36 via a shift and a reciprocal multiply.
	always_comb begin
		code    = word[CODE_W-1:0];
		diff    = code - IDX_BASE;
		quarter = diff[CODE_W-1:2];
		prod    = PROD_W'(quarter) * PROD_W'(RECIP_NINE);
		quot    = prod[PROD_W-1:RECIP_SHIFT];
		if (code >= IDX_BASE) begin
			vertex = IDX_W'(quot);
		end else begin
			vertex = code[IDX_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/tsa_window.sv -----
// Window check and local mapping for one triangle corner.
`default_nettype none
module tsa_window (
	input  wire logic [tsa_pkg::IDX_W-1:0] vertex,
	input  wire logic [tsa_pkg::IDX_W-1:0] window_offset,
	input  wire logic [tsa_pkg::IDX_W-1:0] window_count,
	output logic                           hit,
	output logic      [tsa_pkg::IDX_W-1:0] local_idx
);
	import tsa_pkg::*;

	// The corner hits when it is at or above the offset and within the count.
	always_comb begin
		local_idx = vertex - window_offset;
		hit       = (vertex >= window_offset) && (local_idx < window_count);
	end

endmodule
`default_nettype wire

// ----- rtl/triangle_strip_assembly.sv -----
// Triangle strip assembly: strip words in, one triangle per vertex after the second.
// A word that completes a triangle waits in the input register until the result register is free.
// Throughput: one strip word per cycle unless the output stalls, set by the single input
// register and result register.
// A word that completes no triangle leaves no result and never waits on the output side.
// Reset (arst_n low, asynchronous) clears the window registers, the vertex history,
// the held count and the winding flip, and empties both pipeline registers.
`default_nettype none
module triangle_strip_assembly (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tsa_pkg::IDX_W-1:0]       cfg_wdata,
	tsa_in_if.sink                               strip_in,
	tsa_out_if.source                            tri_out
);
	import tsa_pkg::*;

	logic [IDX_W-1:0]  window_offset_q;
	logic [IDX_W-1:0]  window_count_q;

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              start_s1;

	logic [IDX_W-1:0]  older_q;
	logic [IDX_W-1:0]  newer_q;
	held_t             held_q;
	logic              flip_q;

	logic              valid_s2;
	logic [IDX_W-1:0]  tri_a_s2;
	logic [IDX_W-1:0]  tri_b_s2;
	logic [IDX_W-1:0]  tri_c_s2;
	logic [IDX_W-1:0]  local_a_s2;
	logic [IDX_W-1:0]  local_b_s2;
	logic [IDX_W-1:0]  local_c_s2;
	logic              status_s2;

	logic [IDX_W-1:0]  vertex;
	logic              restart;
	held_t             held_eff;
	logic              flip_eff;
	logic              emits;
	logic [IDX_W-1:0]  corner_a;
	logic [IDX_W-1:0]  corner_b;
	logic              hit_a, hit_b, hit_c;
	logic [IDX_W-1:0]  loc_a, loc_b, loc_c;
	logic              tri_ok;
	logic              out_free;
	logic              fire_s1;
	logic              in_take;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_offset_q <= '0;
			window_count_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WINDOW_OFFSET: window_offset_q <= cfg_wdata;
				REG_WINDOW_COUNT:  window_count_q  <= cfg_wdata;
			endcase
		end
	end

	// Decode the registered strip word.
	tsa_decode u_decode (
		.word   (word_s1),
		.vertex (vertex)
	);

	// Restart handling, corner selection with the winding swap, and handshake.
	always_comb begin
		restart  = word_s1[RESTART_BIT] | start_s1;
		held_eff = restart ? HELD_NONE : held_q;
		flip_eff = restart ? 1'b0 : flip_q;
		emits    = (held_eff == HELD_TWO);
		corner_a = flip_eff ? newer_q : older_q;
		corner_b = flip_eff ? older_q : newer_q;
		out_free = !valid_s2 || tri_out.ready;
		fire_s1  = valid_s1 && (!emits || out_free);
		in_take  = strip_in.valid && strip_in.ready;
	end

	assign strip_in.ready = !valid_s1 || fire_s1;

	// Window checks on all three corners.
	tsa_window u_win_a (
		.vertex        (corner_a),
		.window_offset (window_offset_q),
		.window_count  (window_count_q),
		.hit           (hit_a),
		.local_idx     (loc_a)
	);

	tsa_window u_win_b (
		.vertex        (corner_b),
		.window_offset (window_offset_q),
		.window_count  (window_count_q),
		.hit           (hit_b),
		.local_idx     (loc_b)
	);

	tsa_window u_win_c (
		.vertex        (vertex),
		.window_offset (window_offset_q),
		.window_count  (window_count_q),
		.hit           (hit_c),
		.local_idx     (loc_c)
	);

	assign tri_ok = hit_a && hit_b && hit_c;

	// Input register: control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1  <= strip_in.strip_word;
			start_s1 <= strip_in.strip_start;
		end
	end

	// Vertex history, held count and winding flip advance as each word leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			newer_q <= '0;
			held_q  <= HELD_NONE;
			flip_q  <= 1'b0;
		end else if (fire_s1) begin
			unique case (held_eff)
				HELD_NONE: begin
					older_q <= vertex;
					held_q  <= HELD_ONE;
					flip_q  <= flip_eff;
				end
				HELD_ONE: begin
					newer_q <= vertex;
					held_q  <= HELD_TWO;
					flip_q  <= flip_eff;
				end
				HELD_TWO: begin
					older_q <= newer_q;
					newer_q <= vertex;
					held_q  <= HELD_TWO;
					flip_q  <= ~flip_eff;
				end
				default: begin
					held_q <= HELD_NONE;
					flip_q <= 1'b0;
				end
			endcase
		end
	end

	// Result register: control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1 && emits) begin
			valid_s2 <= 1'b1;
		end else if (tri_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register: payload; a window miss zeroes all local indexes.
	always_ff @(posedge clk) begin
		if (fire_s1 && emits) begin
			tri_a_s2   <= corner_a;
			tri_b_s2   <= corner_b;
			tri_c_s2   <= vertex;
			local_a_s2 <= tri_ok ? loc_a : '0;
			local_b_s2 <= tri_ok ? loc_b : '0;
			local_c_s2 <= tri_ok ? loc_c : '0;
			status_s2  <= !tri_ok;
		end
	end

	// Output transaction.
	assign tri_out.valid       = valid_s2;
	assign tri_out.tri_index_a = tri_a_s2;
	assign tri_out.tri_index_b = tri_b_s2;
	assign tri_out.tri_index_c = tri_c_s2;
	assign tri_out.local_a     = local_a_s2;
	assign tri_out.local_b     = local_b_s2;
	assign tri_out.local_c     = local_c_s2;
	assign tri_out.status      = status_s2;

endmodule
`default_nettype wire

// ----- test/tb_triangle_strip_assembly.sv -----
// Self-checking testbench for the triangle strip assembly block, with a triangle predictor.
`timescale 1ns / 100ps
module tb_triangle_strip_assembly;
	import tsa_pkg::*;

	localparam int CODE_STRIDE  = 36;
	localparam int MAX_CODE     = (1 << CODE_W) - 1;
	localparam int MAX_INDEX    = 1031;
	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_HOLD    = 300;
	localparam int PHASE_ITEMS  = 140;

	// One triangle as it leaves the block.
	typedef struct {
		logic [IDX_W-1:0] index_a;
		logic [IDX_W-1:0] index_b;
		logic [IDX_W-1:0] index_c;
		logic [IDX_W-1:0] local_a;
		logic [IDX_W-1:0] local_b;
		logic [IDX_W-1:0] local_c;
		logic             status;
	} triangle_t;

	// Tracks the strip history and window, and holds the triangles still to come.
	class triangle_predictor;
		int               win_offset;
		int               win_count;
		logic [IDX_W-1:0] older_v;
		logic [IDX_W-1:0] newer_v;
		held_t            held;
		bit               flip;
		triangle_t        expected_tris[$];
		int               errors;

		function new();
			win_offset = 0;
			win_count  = 0;
			older_v    = '0;
			newer_v    = '0;
			held       = HELD_NONE;
			flip       = 1'b0;
			errors     = 0;
		endfunction

		function void set_window(int off, int cnt);
			win_offset = off;
			win_count  = cnt;
		endfunction

		function int outstanding();
			return expected_tris.size();
		endfunction

		function logic [IDX_W-1:0] decode_index(logic [WORD_W-1:0] word);
			int code;
			code = word[CODE_W-1:0];
			if (code >= int'(IDX_BASE))
				return IDX_W'((code - int'(IDX_BASE)) / CODE_STRIDE);
			return IDX_W'(code);
		endfunction

		function bit in_window(logic [IDX_W-1:0] idx);
			int i;
			i = idx;
			return (i >= win_offset) && (i - win_offset < win_count);
		endfunction

		// Notes an accepted strip word and queues the triangle it completes, if any.
		function void take_word(logic [WORD_W-1:0] word, logic start);
			logic [IDX_W-1:0] v;
			logic [IDX_W-1:0] a;
			logic [IDX_W-1:0] b;
			triangle_t        t;
			bit               hit;
			v = decode_index(word);
			if (word[RESTART_BIT] || start) begin
				held = HELD_NONE;
				flip = 1'b0;
			end
			case (held)
				HELD_NONE: begin
					older_v = v;
					held    = HELD_ONE;
				end
				HELD_ONE: begin
					newer_v = v;
					held    = HELD_TWO;
				end
				default: begin
					a       = flip ? newer_v : older_v;
					b       = flip ? older_v : newer_v;
					flip    = ~flip;
					older_v = newer_v;
					newer_v = v;
					hit     = in_window(a) && in_window(b) && in_window(v);
					t.index_a = a;
					t.index_b = b;
					t.index_c = v;
					t.local_a = hit ? IDX_W'(a - win_offset) : '0;
					t.local_b = hit ? IDX_W'(b - win_offset) : '0;
					t.local_c = hit ? IDX_W'(v - win_offset) : '0;
					t.status  = !hit;
					expected_tris.push_back(t);
				end
			endcase
		endfunction

		function void compare_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		// Compares an accepted triangle with the oldest one expected.
		function void check_triangle(triangle_t got);
			triangle_t want;
			if (expected_tris.size() == 0) begin
				$error("triangle a=%0d b=%0d c=%0d arrived with none expected",
					got.index_a, got.index_b, got.index_c);
				errors++;
				return;
			end
			want = expected_tris.pop_front();
			compare_field("tri_index_a", want.index_a, got.index_a);
			compare_field("tri_index_b", want.index_b, got.index_b);
			compare_field("tri_index_c", want.index_c, got.index_c);
			compare_field("local_a", want.local_a, got.local_a);
			compare_field("local_b", want.local_b, got.local_b);
			compare_field("local_c", want.local_c, got.local_c);
			compare_field("status", IDX_W'(want.status), IDX_W'(got.status));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [IDX_W-1:0]     cfg_wdata;

	tsa_in_if  strip_ch ();
	tsa_out_if tri_ch ();

	triangle_predictor sb = new();

	bit tx_idle;
	bit long_hold_req;

	triangle_strip_assembly dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.strip_in  (strip_ch),
		.tri_out   (tri_ch)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#3_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Picks a code whose vertex mostly lands in the current window or on its edges.
	function automatic logic [CODE_W-1:0] random_code();
		int v;
		int sel;
		int room;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return CODE_W'($urandom_range(0, MAX_CODE));
		if (sel < 7 && sb.win_count != 0)
			v = sb.win_offset + $urandom_range(0, sb.win_count - 1);
		else if (sel == 7)
			v = sb.win_offset + sb.win_count;
		else if (sel == 8)
			v = sb.win_offset - 1;
		else
			v = $urandom_range(0, MAX_INDEX);
		if (v > MAX_INDEX)
			v = MAX_INDEX;
		if (v < 0)
			v = 0;
		room = MAX_CODE - int'(IDX_BASE) - CODE_STRIDE * v;
		if (room >= 0 && $urandom_range(0, 1) == 1) begin
			if (room > CODE_STRIDE - 1)
				room = CODE_STRIDE - 1;
			return CODE_W'(int'(IDX_BASE) + CODE_STRIDE * v + $urandom_range(0, room));
		end
		return CODE_W'(v);
	endfunction

	// Offers one strip word and returns at the edge where the transaction completes.
	task automatic send_word(input logic [WORD_W-1:0] word, input logic start);
		int gap;
		gap = tx_idle ? $urandom_range(0, 12) : 0;
		if (gap != 0) begin
			strip_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		strip_ch.valid       <= 1'b1;
		strip_ch.strip_word  <= word;
		strip_ch.strip_start <= start;
		@(posedge clk);
		while (!strip_ch.ready) @(posedge clk);
		sb.take_word(word, start);
	endtask

	// Stops offering words and waits until every triangle has arrived.
	task automatic wait_idle(input int extra);
		strip_ch.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Writes both window registers on consecutive edges.
	task automatic configure_window(input int off, input int cnt);
		cfg_we    <= 1'b1;
		cfg_index <= REG_WINDOW_OFFSET;
		cfg_wdata <= IDX_W'(off);
		@(posedge clk);
		cfg_index <= REG_WINDOW_COUNT;
		cfg_wdata <= IDX_W'(cnt);
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_window(off, cnt);
	endtask

	// Mostly well-formed strips of random length, with stray restarts and unmarked joins.
	task automatic run_strips(input int n_items);
		int               sent;
		int               len;
		int               pick;
		logic [WORD_W-1:0] word;
		logic             start;
		sent = 0;
		while (sent < n_items) begin
			len  = $urandom_range(1, 12);
			pick = $urandom_range(0, 9);
			for (int k = 0; k < len && sent < n_items; k++) begin
				word  = {1'b0, 1'($urandom_range(0, 1)), random_code()};
				start = 1'b0;
				if (k == 0) begin
					if (pick < 4)
						start = 1'b1;
					else if (pick < 7)
						word[RESTART_BIT] = 1'b1;
					else if (pick < 8) begin
						start = 1'b1;
						word[RESTART_BIT] = 1'b1;
					end
				end else if ($urandom_range(0, 39) == 0) begin
					word[RESTART_BIT] = 1'b1;
				end
				send_word(word, start);
				sent++;
			end
		end
	endtask

	// Result side: random stalls per triangle, in stretches, plus one long hold-off.
	initial begin : triangle_sink
		int        stall;
		int        taken;
		bit        rx_idle;
		triangle_t got;
		taken   = 0;
		rx_idle = 1'b0;
		tri_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 12) : 0;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall != 0) begin
				tri_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tri_ch.ready <= 1'b1;
			@(posedge clk);
			while (!tri_ch.valid) @(posedge clk);
			got.index_a = tri_ch.tri_index_a;
			got.index_b = tri_ch.tri_index_b;
			got.index_c = tri_ch.tri_index_c;
			got.local_a = tri_ch.local_a;
			got.local_b = tri_ch.local_b;
			got.local_c = tri_ch.local_c;
			got.status  = tri_ch.status;
			sb.check_triangle(got);
			taken++;
			if (taken % 40 == 0)
				rx_idle = $urandom_range(0, 1);
		end
	end

	// Stimulus: directed strips first, then random phases over several windows.
	initial begin : stimulus
		int phase_off[8];
		int phase_cnt[8];
		phase_off = '{0, 0, 1031, 500, 0, 200, 0, 1000};
		phase_cnt = '{1032, 0, 1032, 40, 1, 300, 0, 32};
		tx_idle              = 1'b1;
		long_hold_req        = 1'b0;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= REG_WINDOW_OFFSET;
		cfg_wdata            <= '0;
		strip_ch.valid       <= 1'b0;
		strip_ch.strip_word  <= '0;
		strip_ch.strip_start <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Window left at reset (empty): every triangle misses. Bit 14 is ignored.
		send_word(16'h0000, 1'b1);
		send_word(16'h7FFF, 1'b0);
		send_word(16'h0407, 1'b0);
		send_word(16'h0408, 1'b0);
		wait_idle(DRAIN_CYCLES);

		// Full window: restarts by bit 15, by strip_start and by both, decode edges.
		configure_window(0, 1032);
		send_word(16'h8407, 1'b0);
		send_word(16'h042C, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'h3FFF, 1'b0);
		send_word(16'h4005, 1'b0);
		send_word(16'h0407, 1'b1);
		send_word(16'hC000, 1'b0);
		send_word(16'h0408, 1'b0);
		send_word(16'h044B, 1'b0);
		send_word(16'h044C, 1'b0);
		send_word(16'h046F, 1'b0);
		send_word(16'hBFFF, 1'b1);
		wait_idle(DRAIN_CYCLES);

		// Single-vertex window at the top index: hits, then a miss below the offset.
		configure_window(1031, 1);
		send_word(16'h0407, 1'b1);
		send_word(16'h0407, 1'b0);
		send_word(16'h0407, 1'b0);
		send_word(16'h0407, 1'b0);
		send_word(16'h0406, 1'b0);

		// Random phases, each under its own window.
		phase_off[6] = $urandom_range(0, MAX_INDEX);
		phase_cnt[6] = $urandom_range(0, 1032);
		for (int p = 0; p < 8; p++) begin
			wait_idle(DRAIN_CYCLES);
			configure_window(phase_off[p], phase_cnt[p]);
			tx_idle = p[0];
			if (p == 3) begin
				// The sender keeps offering while the result side holds off.
				tx_idle = 1'b0;
				long_hold_req = 1'b1;
			end
			if (p == 5) begin
				// Sender pauses mid-phase until every triangle is out.
				run_strips(PHASE_ITEMS / 2);
				wait_idle(0);
				run_strips(PHASE_ITEMS / 2);
			end else begin
				run_strips(PHASE_ITEMS);
			end
		end

		wait_idle(10);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
